FILE: rtl/lrpc_pkg.sv
// ----------------------------------------------------------------------------
// lrpc_pkg: shared types and constants of the log record parser/checker
// Parse phases, result kinds, the result record and the push bundle that
// the parser hands to the result queue.
// ----------------------------------------------------------------------------
package lrpc_pkg;

	// Arithmetic and field sizes
	localparam logic [31:0] HASH_MUL   = 32'd31;
	localparam logic [31:0] WORD_BYTES = 32'd4;
	localparam logic [31:0] LONG_BYTES = 32'd8;

	// Default depth of the result queue (at least two)
	localparam int RES_DEPTH_DEF = 4;

	// Result kinds
	localparam logic [2:0] KIND_KEY   = 3'd0;
	localparam logic [2:0] KIND_VAL   = 3'd1;
	localparam logic [2:0] KIND_OK    = 3'd2;
	localparam logic [2:0] KIND_BAD   = 3'd3;
	localparam logic [2:0] KIND_CLEAN = 3'd4;
	localparam logic [2:0] KIND_TRUNC = 3'd5;

	// Parse phase: which field the next byte belongs to
	typedef enum logic [3:0] {
		PH_SIZE = 4'd0,
		PH_OP   = 4'd1,
		PH_KLEN = 4'd2,
		PH_KEY  = 4'd3,
		PH_VLEN = 4'd4,
		PH_VAL  = 4'd5,
		PH_TIME = 4'd6,
		PH_SEQ  = 4'd7,
		PH_CSUM = 4'd8,
		PH_SKIP = 4'd9
	} phase_t;

	// One result item
	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         payload_byte;
		logic [7:0]         record_op;
		logic [31:0]        key_length;
		logic [31:0]        value_length;
		logic signed [63:0] time_stamp;
		logic [63:0]        sequence_number;
		logic               after_snapshot;
		logic               last;
	} result_t;

	// Up to two results produced by one input item, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

FILE: rtl/lrpc_if.sv
// ----------------------------------------------------------------------------
// lrpc channel interfaces
// Valid/ready channels for log bytes in, results out and the snapshot
// register write port.
// ----------------------------------------------------------------------------

// Log byte channel
interface lrpc_log_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Result channel
interface lrpc_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         payload_byte;
	logic [7:0]         record_op;
	logic [31:0]        key_length;
	logic [31:0]        value_length;
	logic signed [63:0] time_stamp;
	logic [63:0]        sequence_number;
	logic               after_snapshot;
	logic               last;

	modport source (output valid, output kind, output payload_byte, output record_op,
		output key_length, output value_length, output time_stamp,
		output sequence_number, output after_snapshot, output last, input ready);
	modport sink   (input valid, input kind, input payload_byte, input record_op,
		input key_length, input value_length, input time_stamp,
		input sequence_number, input after_snapshot, input last, output ready);
endinterface

// Snapshot register write channel
interface lrpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/log_record_parser_checker_unit.sv
// ----------------------------------------------------------------------------
// log_record_parser_checker_unit: streaming parser and checker of
// length-prefixed log records
//
//   channel     dir   payload                                    handshake
//   log_in      in    op, data_byte                              valid/ready
//   result_out  out   kind, payload_byte, record fields, last    valid/ready
//   cfg         in    data = snapshot sequence (64 bit)          valid/ready
//
// One log byte per cycle while the queue has room: a taken byte sits in the
// input register, is stepped through the parser once the queue has room for
// two results, and its results land in a small queue from which result_out is
// served. A byte yields at most two results.
// Input ready drops only while the queue lacks room for two results.
// Reset clears the parse state, the queue and the snapshot register.
// ----------------------------------------------------------------------------
module log_record_parser_checker_unit
	import lrpc_pkg::*;
#(
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lrpc_log_if.sink  log_in,
	lrpc_res_if.source result_out,
	lrpc_cfg_if.sink  cfg
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        room;
	logic        not_empty;
	logic        pop;
	logic [63:0] snapshot_q;
	push_t       push;
	result_t     head;

	// Snapshot register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snapshot_q <= '0;
		end else if (cfg.valid) begin
			snapshot_q <= cfg.data;
		end
	end

	// Input register
	assign advance      = valid_s1 && room;
	assign log_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (log_in.valid && log_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (log_in.valid && log_in.ready) begin
			op_s1   <= log_in.op;
			byte_s1 <= log_in.data_byte;
		end
	end

	// Parser step
	lrpc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.item_op    (op_s1),
		.item_byte  (byte_s1),
		.snapshot   (snapshot_q),
		.push       (push)
	);

	// Result queue
	assign pop = result_out.valid && result_out.ready;

	lrpc_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (not_empty),
		.head      (head)
	);

	// Output channel
	assign result_out.valid           = not_empty;
	assign result_out.kind            = head.kind;
	assign result_out.payload_byte    = head.payload_byte;
	assign result_out.record_op       = head.record_op;
	assign result_out.key_length      = head.key_length;
	assign result_out.value_length    = head.value_length;
	assign result_out.time_stamp      = head.time_stamp;
	assign result_out.sequence_number = head.sequence_number;
	assign result_out.after_snapshot  = head.after_snapshot;
	assign result_out.last            = head.last;

endmodule

FILE: rtl/lrpc_parser.sv
// ----------------------------------------------------------------------------
// lrpc_parser: record parse state and per-item step logic
// Consumes one registered item when item_valid is high, updates the parse
// state and reports up to two results for that item.
// ----------------------------------------------------------------------------
module lrpc_parser
	import lrpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_op,
	input  logic [7:0]  item_byte,
	input  logic [63:0] snapshot,
	output push_t       push
);

	phase_t      phase_q, phase_d;
	logic [31:0] idx_q, idx_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  op_q, op_d;
	logic [31:0] klen_q, klen_d;
	logic [31:0] vlen_q, vlen_d;
	logic [63:0] time_q, time_d;
	logic [63:0] seq_q, seq_d;
	logic [31:0] hash_q, hash_d;
	logic [31:0] stored_q, stored_d;
	logic        halted_q, halted_d;

	logic [31:0] idx_inc;
	logic [31:0] rem_dec;
	logic [31:0] lane4;
	logic [63:0] lane8;
	logic [31:0] hash_upd;
	logic        eol;
	logic        clean;
	logic        kv_valid;
	logic [2:0]  kv_kind;
	logic        sum_valid;
	logic        sum_ok;
	logic        csum_done;
	result_t     kv_res;
	result_t     sum_res;
	result_t     end_res;

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			idx_q    <= '0;
			rem_q    <= '0;
			op_q     <= '0;
			klen_q   <= '0;
			vlen_q   <= '0;
			time_q   <= '0;
			seq_q    <= '0;
			hash_q   <= '0;
			stored_q <= '0;
			halted_q <= 1'b0;
		end else if (item_valid) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			rem_q    <= rem_d;
			op_q     <= op_d;
			klen_q   <= klen_d;
			vlen_q   <= vlen_d;
			time_q   <= time_d;
			seq_q    <= seq_d;
			hash_q   <= hash_d;
			stored_q <= stored_d;
			halted_q <= halted_d;
		end
	end

	// Next state for one item
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		rem_d     = rem_q;
		op_d      = op_q;
		klen_d    = klen_q;
		vlen_d    = vlen_q;
		time_d    = time_q;
		seq_d     = seq_q;
		hash_d    = hash_q;
		stored_d  = stored_q;
		halted_d  = halted_q;
		eol       = 1'b0;
		clean     = 1'b0;
		kv_valid  = 1'b0;
		kv_kind   = KIND_KEY;
		sum_valid = 1'b0;
		sum_ok    = 1'b0;
		csum_done = 1'b0;

		idx_inc  = idx_q + 32'd1;
		rem_dec  = rem_q - 32'd1;
		lane4    = {24'd0, item_byte} << {idx_q[1:0], 3'b000};
		lane8    = {56'd0, item_byte} << {idx_q[2:0], 3'b000};
		hash_upd = hash_q * HASH_MUL + {24'd0, item_byte};

		if (item_op) begin
			// end of log: report and return to a fresh parse
			eol      = 1'b1;
			clean    = !halted_q && (phase_q == PH_SIZE) && (idx_q == '0);
			phase_d  = PH_SIZE;
			idx_d    = '0;
			rem_d    = '0;
			op_d     = '0;
			klen_d   = '0;
			vlen_d   = '0;
			time_d   = '0;
			seq_d    = '0;
			hash_d   = '0;
			stored_d = '0;
			halted_d = 1'b0;
		end else if (!halted_q) begin
			if (phase_q == PH_SIZE) begin
				rem_d = rem_q | lane4;
				idx_d = idx_inc;
				if (idx_inc == WORD_BYTES) begin
					// size complete: start a fresh record
					op_d     = '0;
					klen_d   = '0;
					vlen_d   = '0;
					time_d   = '0;
					seq_d    = '0;
					hash_d   = '0;
					stored_d = '0;
					idx_d    = '0;
					if ((rem_q | lane4) == '0) begin
						sum_valid = 1'b1;
						halted_d  = 1'b1;
					end else begin
						phase_d = PH_OP;
					end
				end
			end else begin
				rem_d = rem_dec;
				case (phase_q)
					PH_OP: begin
						op_d    = item_byte;
						phase_d = PH_KLEN;
						idx_d   = '0;
					end
					PH_KLEN: begin
						klen_d = klen_q | lane4;
						idx_d  = idx_inc;
						if (idx_inc == WORD_BYTES) begin
							phase_d = ((klen_q | lane4) != '0) ? PH_KEY : PH_VLEN;
							idx_d   = '0;
						end
					end
					PH_KEY: begin
						kv_valid = 1'b1;
						kv_kind  = KIND_KEY;
						hash_d   = hash_upd;
						idx_d    = idx_inc;
						if (idx_inc >= klen_q) begin
							phase_d = PH_VLEN;
							idx_d   = '0;
						end
					end
					PH_VLEN: begin
						vlen_d = vlen_q | lane4;
						idx_d  = idx_inc;
						if (idx_inc == WORD_BYTES) begin
							phase_d = ((vlen_q | lane4) != '0) ? PH_VAL : PH_TIME;
							idx_d   = '0;
						end
					end
					PH_VAL: begin
						kv_valid = 1'b1;
						kv_kind  = KIND_VAL;
						hash_d   = hash_upd;
						idx_d    = idx_inc;
						if (idx_inc >= vlen_q) begin
							phase_d = PH_TIME;
							idx_d   = '0;
						end
					end
					PH_TIME: begin
						time_d = time_q | lane8;
						idx_d  = idx_inc;
						if (idx_inc == LONG_BYTES) begin
							phase_d = PH_SEQ;
							idx_d   = '0;
						end
					end
					PH_SEQ: begin
						seq_d = seq_q | lane8;
						idx_d = idx_inc;
						if (idx_inc == LONG_BYTES) begin
							phase_d = PH_CSUM;
							idx_d   = '0;
						end
					end
					PH_CSUM: begin
						stored_d = stored_q | lane4;
						idx_d    = idx_inc;
						if (idx_inc == WORD_BYTES) begin
							csum_done = 1'b1;
						end
					end
					default: begin
						// trailing bytes of the record
						if (rem_dec == '0) begin
							phase_d = PH_SIZE;
							idx_d   = '0;
						end
					end
				endcase

				// record end: checksum verdict or overrun
				if (phase_q != PH_SKIP) begin
					if (csum_done) begin
						sum_valid = 1'b1;
						sum_ok    = (stored_d == hash_d);
						if (!sum_ok) begin
							halted_d = 1'b1;
						end else begin
							phase_d = (rem_dec != '0) ? PH_SKIP : PH_SIZE;
							idx_d   = '0;
						end
					end else if (rem_dec == '0) begin
						sum_valid = 1'b1;
						halted_d  = 1'b1;
					end
				end
			end
		end
	end

	// Result records
	always_comb begin
		kv_res              = '0;
		kv_res.kind         = kv_kind;
		kv_res.payload_byte = item_byte;

		end_res      = '0;
		end_res.kind = clean ? KIND_CLEAN : KIND_TRUNC;
		end_res.last = 1'b1;

		sum_res                 = '0;
		sum_res.kind            = sum_ok ? KIND_OK : KIND_BAD;
		sum_res.record_op       = op_d;
		sum_res.key_length      = klen_d;
		sum_res.value_length    = vlen_d;
		sum_res.time_stamp      = time_d;
		sum_res.sequence_number = seq_d;
		sum_res.after_snapshot  = sum_ok && (seq_d > snapshot);
		sum_res.last            = 1'b1;

		push = '0;
		if (!item_valid) begin
			push.count = 2'd0;
		end else if (eol) begin
			push.count = 2'd1;
			push.first = end_res;
		end else if (kv_valid && sum_valid) begin
			push.count  = 2'd2;
			push.first  = kv_res;
			push.second = sum_res;
		end else if (kv_valid) begin
			push.count      = 2'd1;
			push.first      = kv_res;
			push.first.last = 1'b1;
		end else if (sum_valid) begin
			push.count = 2'd1;
			push.first = sum_res;
		end
	end

endmodule

FILE: rtl/lrpc_res_fifo.sv
// ----------------------------------------------------------------------------
// lrpc_res_fifo: result queue
// Takes up to two results per cycle, hands out one per cycle in order while pop is high.
// room is high while at least two entries are free.
// ----------------------------------------------------------------------------
module lrpc_res_fifo
	import lrpc_pkg::*;
#(
	parameter int DEPTH = RES_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output logic    room,
	output logic    not_empty,
	output result_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW-1:0]   wp_1, wp_2, rp_1;
	logic [CW-1:0]   count_q;

	// Pointer advance with wrap
	always_comb begin
		wp_1 = (wp_q == LAST_PTR) ? '0 : wp_q + PW'(1);
		wp_2 = (wp_1 == LAST_PTR) ? '0 : wp_1 + PW'(1);
		rp_1 = (rp_q == LAST_PTR) ? '0 : rp_q + PW'(1);
	end

	assign room      = (count_q <= CW'(DEPTH - 2));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rp_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wp_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wp_1] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			case (push.count)
				2'd1:    wp_q <= wp_1;
				2'd2:    wp_q <= wp_2;
				default: wp_q <= wp_q;
			endcase
			if (pop) begin
				rp_q <= rp_1;
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

FILE: sim/tb_log_record_parser_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_log_record_parser_checker_unit: self-checking bench of the log parser
// Streams framed log records (well-formed, bad checksum, cut short, zero size,
// oversized length fields, trailing bytes, truncated logs) through the block.
// A behavioral copy of the parser predicts every result item, and a scoreboard
// compares them field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_log_record_parser_checker_unit
	import lrpc_pkg::*;
();

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Shapes of generated records
	typedef enum int {
		REC_OK,
		REC_TRAIL,
		REC_BAD_SUM,
		REC_CUT,
		REC_ZERO,
		REC_HUGE_KEY,
		REC_HUGE_VAL,
		REC_TRUNC
	} rec_shape_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} log_item_t;

	logic clk = 1'b0;
	logic arst_n;

	lrpc_log_if log_ch();
	lrpc_res_if res_ch();
	lrpc_cfg_if cfg_ch();

	log_record_parser_checker_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.log_in     (log_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	always #5 clk = ~clk;

	// Parser shadow state
	logic [63:0] snapshot_seq;
	phase_t      parse_phase;
	logic [31:0] byte_idx;
	logic [31:0] rec_left;
	logic [7:0]  rec_op;
	logic [31:0] rec_klen;
	logic [31:0] rec_vlen;
	logic [63:0] rec_time;
	logic [63:0] rec_seq;
	logic [31:0] hash_acc;
	logic [31:0] hash_stored;
	logic        parse_halted;

	// Stimulus and scoreboard bookkeeping
	log_item_t log_feed[$];
	result_t   results_due[$];
	logic [7:0] frame[$];
	log_item_t next_item;
	int items_in_flight = 0;
	int items_accepted  = 0;
	int queued_total    = 0;
	int records_made    = 0;
	int errors          = 0;
	int send_wait       = 0;
	int recv_wait       = 0;
	bit send_burst      = 0;
	bit recv_burst      = 0;
	logic hold_off      = 1'b0;

	// ------------------------------------------------------------------
	// Parser prediction
	// ------------------------------------------------------------------
	task automatic restart_parse();
		parse_phase  = PH_SIZE;
		byte_idx     = '0;
		rec_left     = '0;
		rec_op       = '0;
		rec_klen     = '0;
		rec_vlen     = '0;
		rec_time     = '0;
		rec_seq      = '0;
		hash_acc     = '0;
		hash_stored  = '0;
		parse_halted = 1'b0;
	endtask

	task automatic enter_phase(input phase_t p);
		parse_phase = p;
		byte_idx    = '0;
	endtask

	function automatic result_t record_summary(input bit ok);
		result_t r;
		r = '0;
		r.kind            = ok ? KIND_OK : KIND_BAD;
		r.record_op       = rec_op;
		r.key_length      = rec_klen;
		r.value_length    = rec_vlen;
		r.time_stamp      = rec_time;
		r.sequence_number = rec_seq;
		r.after_snapshot  = ok && (rec_seq > snapshot_seq);
		return r;
	endfunction

	function automatic result_t data_result(input logic [2:0] kind, input logic [7:0] b);
		result_t r;
		r = '0;
		r.kind         = kind;
		r.payload_byte = b;
		return r;
	endfunction

	// Advance the shadow parser by one accepted item and queue its results
	task automatic parse_log_byte(input logic op, input logic [7:0] b);
		logic [4:0]  sh4;
		logic [5:0]  sh8;
		logic [31:0] b32;
		logic [63:0] b64;
		logic [31:0] size;
		bit          csum_done;
		bit          skipped;
		bit          ok;
		result_t     outs[2];
		int          n;
		sh4       = {byte_idx[1:0], 3'b000};
		sh8       = {byte_idx[2:0], 3'b000};
		b32       = {24'd0, b};
		b64       = {56'd0, b};
		csum_done = 0;
		skipped   = 0;
		n         = 0;
		if (op == OP_END) begin
			outs[0] = '0;
			outs[0].kind = (!parse_halted && parse_phase == PH_SIZE && byte_idx == 0) ?
				KIND_CLEAN : KIND_TRUNC;
			n = 1;
			restart_parse();
		end else if (!parse_halted) begin
			if (parse_phase == PH_SIZE) begin
				rec_left = rec_left | (b32 << sh4);
				byte_idx++;
				if (byte_idx >= WORD_BYTES) begin
					size = rec_left;
					restart_parse();
					rec_left = size;
					if (size == 0) begin
						// empty record is corrupt by definition
						outs[0] = record_summary(0);
						n = 1;
						parse_halted = 1'b1;
					end else begin
						enter_phase(PH_OP);
					end
				end
			end else begin
				rec_left--;
				case (parse_phase)
				PH_OP: begin
					rec_op = b;
					enter_phase(PH_KLEN);
				end
				PH_KLEN: begin
					rec_klen = rec_klen | (b32 << sh4);
					byte_idx++;
					if (byte_idx >= WORD_BYTES)
						enter_phase(rec_klen != 0 ? PH_KEY : PH_VLEN);
				end
				PH_KEY: begin
					outs[n] = data_result(KIND_KEY, b);
					n++;
					hash_acc = hash_acc * HASH_MUL + b32;
					byte_idx++;
					if (byte_idx >= rec_klen)
						enter_phase(PH_VLEN);
				end
				PH_VLEN: begin
					rec_vlen = rec_vlen | (b32 << sh4);
					byte_idx++;
					if (byte_idx >= WORD_BYTES)
						enter_phase(rec_vlen != 0 ? PH_VAL : PH_TIME);
				end
				PH_VAL: begin
					outs[n] = data_result(KIND_VAL, b);
					n++;
					hash_acc = hash_acc * HASH_MUL + b32;
					byte_idx++;
					if (byte_idx >= rec_vlen)
						enter_phase(PH_TIME);
				end
				PH_TIME: begin
					rec_time = rec_time | (b64 << sh8);
					byte_idx++;
					if (byte_idx >= LONG_BYTES)
						enter_phase(PH_SEQ);
				end
				PH_SEQ: begin
					rec_seq = rec_seq | (b64 << sh8);
					byte_idx++;
					if (byte_idx >= LONG_BYTES)
						enter_phase(PH_CSUM);
				end
				PH_CSUM: begin
					hash_stored = hash_stored | (b32 << sh4);
					byte_idx++;
					if (byte_idx >= WORD_BYTES)
						csum_done = 1;
				end
				default: begin
					// trailing bytes after the checksum are dropped silently
					skipped = 1;
					if (rec_left == 0)
						enter_phase(PH_SIZE);
				end
				endcase
				if (!skipped) begin
					if (csum_done) begin
						ok = (hash_stored == hash_acc);
						outs[n] = record_summary(ok);
						n++;
						if (!ok)
							parse_halted = 1'b1;
						else
							enter_phase(rec_left != 0 ? PH_SKIP : PH_SIZE);
					end else if (rec_left == 0) begin
						// record size ran out before the checksum
						outs[n] = record_summary(0);
						n++;
						parse_halted = 1'b1;
					end
				end
			end
		end
		if (n > 0)
			outs[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			results_due.insert(results_due.size(), outs[i]);
	endtask

	// ------------------------------------------------------------------
	// Log input driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_ch.valid     <= 1'b0;
			log_ch.op        <= OP_BYTE;
			log_ch.data_byte <= 8'd0;
			send_wait = 0;
		end else begin
			if (log_ch.valid && log_ch.ready) begin
				parse_log_byte(log_ch.op, log_ch.data_byte);
				items_in_flight--;
				items_accepted++;
			end
			if (!log_ch.valid || log_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					log_ch.valid <= 1'b0;
				end else if (log_feed.size() != 0) begin
					next_item = log_feed.pop_front();
					log_ch.valid     <= 1'b1;
					log_ch.op        <= next_item.op;
					log_ch.data_byte <= next_item.data_byte;
					if ($urandom_range(0, 31) == 0)
						send_burst = !send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 6);
				end else begin
					log_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and scoreboard
	// ------------------------------------------------------------------
	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
		end
	endfunction

	task automatic score_result();
		result_t want;
		if (results_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual kind %0d",
				$time, res_ch.kind);
		end else begin
			want = results_due.pop_front();
			compare_field("kind", 64'(want.kind), 64'(res_ch.kind));
			compare_field("payload_byte", 64'(want.payload_byte),
				64'(res_ch.payload_byte));
			compare_field("record_op", 64'(want.record_op), 64'(res_ch.record_op));
			compare_field("key_length", 64'(want.key_length), 64'(res_ch.key_length));
			compare_field("value_length", 64'(want.value_length),
				64'(res_ch.value_length));
			compare_field("time_stamp", want.time_stamp, res_ch.time_stamp);
			compare_field("sequence_number", want.sequence_number,
				res_ch.sequence_number);
			compare_field("after_snapshot", 64'(want.after_snapshot),
				64'(res_ch.after_snapshot));
			compare_field("last", 64'(want.last), 64'(res_ch.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				score_result();
				if ($urandom_range(0, 31) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 6);
			end
			if (hold_off) begin
				res_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Long result back-pressure so the result queue fills and the input stalls
	initial begin
		for (int k = 1; k <= 2; k++) begin
			do @(negedge clk); while (items_accepted < 650 * k);
			@(posedge clk);
			hold_off <= 1'b1;
			repeat (300) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] b);
		log_feed.insert(log_feed.size(), '{OP_BYTE, b});
		items_in_flight++;
		queued_total++;
	endtask

	task automatic queue_end();
		log_feed.insert(log_feed.size(), '{OP_END, 8'($urandom)});
		items_in_flight++;
		queued_total++;
	endtask

	task automatic queue_frame(input int count);
		for (int i = 0; i < count; i++)
			queue_byte(frame[i]);
	endtask

	task automatic put_le(input logic [63:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			frame.insert(frame.size(), v[8*i +: 8]);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6);
		if (r < 95)
			return $urandom_range(7, 20);
		return $urandom_range(21, 48);
	endfunction

	function automatic logic [63:0] pick_time();
		case ($urandom_range(0, 7))
		0: return 64'h8000_0000_0000_0000;
		1: return 64'h7FFF_FFFF_FFFF_FFFF;
		2: return 64'd0;
		3: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// Sequence numbers clustered around the snapshot so the flag flips
	function automatic logic [63:0] pick_seq();
		case ($urandom_range(0, 7))
		0: return snapshot_seq;
		1: return snapshot_seq + 64'd1;
		2: return snapshot_seq - 64'd1;
		3: return 64'd0;
		4: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// Build one framed record (size word + body) into frame
	task automatic build_record(input rec_shape_t shape);
		int          klen;
		int          vlen;
		int          n;
		logic [31:0] sum;
		logic [31:0] size_word;
		logic [7:0]  b;
		frame.delete();
		put_le(64'd0, 4);
		klen = pick_len();
		vlen = pick_len();
		sum  = '0;
		if (shape != REC_ZERO) begin
			frame.insert(frame.size(), 8'($urandom));
			if (shape == REC_HUGE_KEY) begin
				put_le(64'({1'b1, 31'($urandom)}), 4);
				repeat ($urandom_range(0, 12)) frame.insert(frame.size(), 8'($urandom));
			end else begin
				put_le(64'(klen), 4);
				for (int i = 0; i < klen; i++) begin
					b = 8'($urandom);
					sum = sum * HASH_MUL + {24'd0, b};
					frame.insert(frame.size(), b);
				end
				if (shape == REC_HUGE_VAL) begin
					put_le(64'({1'b1, 31'($urandom)}), 4);
					repeat ($urandom_range(0, 12))
						frame.insert(frame.size(), 8'($urandom));
				end else begin
					put_le(64'(vlen), 4);
					for (int i = 0; i < vlen; i++) begin
						b = 8'($urandom);
						sum = sum * HASH_MUL + {24'd0, b};
						frame.insert(frame.size(), b);
					end
					put_le(pick_time(), 8);
					put_le(pick_seq(), 8);
					if (shape == REC_BAD_SUM)
						sum = sum ^ ($urandom | 32'd1);
					put_le(64'(sum), 4);
					if (shape == REC_TRAIL)
						repeat ($urandom_range(1, 6))
							frame.insert(frame.size(), 8'($urandom));
				end
			end
		end
		n = frame.size() - 4;
		if (shape == REC_CUT)
			n = $urandom_range(1, n - 1);
		while (frame.size() > n + 4)
			void'(frame.pop_back());
		size_word = 32'(n);
		for (int i = 0; i < 4; i++)
			frame[i] = size_word[8*i +: 8];
	endtask

	function automatic rec_shape_t pick_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 62) return REC_OK;
		if (r < 76) return REC_TRAIL;
		if (r < 82) return REC_BAD_SUM;
		if (r < 87) return REC_CUT;
		if (r < 89) return REC_ZERO;
		if (r < 92) return REC_HUGE_KEY;
		if (r < 95) return REC_HUGE_VAL;
		return REC_TRUNC;
	endfunction

	// One log: a run of records closed by an end-of-log item
	task automatic queue_log();
		int         nrec;
		rec_shape_t shape;
		nrec = $urandom_range(0, 6);
		for (int i = 0; i < nrec; i++) begin
			// every shape shows up early, then weighted toward good records
			shape = (records_made < 8) ? rec_shape_t'(records_made) : pick_shape();
			records_made++;
			build_record(shape);
			if (shape == REC_TRUNC) begin
				queue_frame($urandom_range(1, frame.size() - 1));
				queue_end();
				return;
			end
			queue_frame(frame.size());
			if (shape != REC_OK && shape != REC_TRAIL) begin
				// halted: stray bytes are ignored until the end of log
				repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
				queue_end();
				return;
			end
		end
		queue_end();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (items_in_flight != 0 || results_due.size() != 0);
		// a byte that yields no result may still be in the pipe
		repeat (6) @(posedge clk);
	endtask

	task automatic write_snapshot(input logic [63:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		snapshot_seq = v;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int          start;
		logic [63:0] plan[7];
		arst_n           = 1'b0;
		log_ch.valid     = 1'b0;
		log_ch.op        = OP_BYTE;
		log_ch.data_byte = 8'd0;
		res_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = 64'd0;
		snapshot_seq     = 64'd0;
		restart_parse();
		plan[0] = '1;
		plan[1] = {$urandom, $urandom};
		plan[2] = 64'd0;
		plan[3] = 64'h8000_0000_0000_0000;
		plan[4] = 64'd1;
		plan[5] = {$urandom, $urandom};
		plan[6] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty log, partial size field, zero size then halted byte
		queue_end();
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_end();
		repeat (4) queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_end();
		queue_end();

		// Random logs under a range of snapshot settings
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			write_snapshot(plan[p]);
			@(negedge clk);
			start = queued_total;
			while (queued_total - start < 165)
				queue_log();
		end

		wait_drained();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
